// ===== rtl/sdo_pkg.sv =====
// Package for the stochastic dominance unit: fixed field widths, request
// codes, transaction payload types and depth helpers.
// No dependencies.
package sdo_pkg;

  localparam int K          = 8;    // group columns
  localparam int FREQ_BITS  = 16;   // Q0.16 frequency
  localparam int SUM_BITS   = FREQ_BITS + 6;
  localparam int GROUP_W    = 3;
  localparam int COLS_W     = 4;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam int POSET_SIZE_DEF = 256;
  localparam int N_OBS_DEF      = 64;

  // field widths bound what any parameter can reach
  localparam int ELEM_SPAN = 256;
  localparam int ROW_SPAN  = 64;

  // register index, taken from paddr[PADDR_W-1:2]
  localparam logic [PADDR_W-3:0] REG_COLS_IN_USE = '0;

  typedef enum logic [1:0] {
    REQ_FREQ = 2'd0,
    REQ_MAP  = 2'd1,
    REQ_EXT  = 2'd2
  } req_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  elem;
    logic [5:0]  row;
    logic [2:0]  col;
    logic [15:0] freq;
    logic        observed;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [2:0] group_index;
    logic [7:0] dominates_mask;
    logic       last_res;
  } out_item_t;

  // per-stage control of an extension element
  typedef struct packed {
    logic hit;   // observed element, add its row
    logic last;  // closes the run
  } ctl_t;

  typedef logic [K-1:0][FREQ_BITS-1:0] row_t;
  typedef logic [K-1:0][K-1:0]         mask_arr_t;
  typedef logic [SUM_BITS-1:0]         sum_t;

  function automatic int map_depth(input int n_elems);
    return (n_elems < ELEM_SPAN) ? n_elems : ELEM_SPAN;
  endfunction

  function automatic int obs_depth(input int n_obs);
    return (n_obs < ROW_SPAN) ? n_obs : ROW_SPAN;
  endfunction

  function automatic int row_aw(input int n_obs);
    return (obs_depth(n_obs) > 1) ? $clog2(obs_depth(n_obs)) : 1;
  endfunction

endpackage

// ===== rtl/sdo_if.sv =====
// Valid/ready channel interfaces for input items and result masks.
// Depends on sdo_pkg.
interface sdo_in_if;
  import sdo_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sdo_out_if;
  import sdo_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sdo_map.sv =====
// Element-to-row map: valid bit per element in flops, row index in memory.
// First pipeline stage of extension elements. Depends on sdo_pkg.
module sdo_map #(
  parameter int POSET_SIZE = sdo_pkg::POSET_SIZE_DEF,
  parameter int N_OBS      = sdo_pkg::N_OBS_DEF,
  localparam int ROW_AW    = sdo_pkg::row_aw(N_OBS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  sdo_pkg::in_item_t  item_i,
  output sdo_pkg::ctl_t      ctl_o,
  output logic [ROW_AW-1:0]  row_o
);
  import sdo_pkg::*;

  localparam int MAP_DEPTH  = map_depth(POSET_SIZE);
  localparam int MAP_AW     = $clog2(MAP_DEPTH);
  localparam int FREQ_DEPTH = obs_depth(N_OBS);

  logic [MAP_DEPTH-1:0] vld_q;
  logic [ROW_AW-1:0]    map_mem [MAP_DEPTH];
  logic [ROW_AW-1:0]    row_q;
  ctl_t                 ctl_q;
  logic                 elem_ok, row_ok, is_map, is_ext;
  logic [MAP_AW-1:0]    eidx;

  assign elem_ok = 32'(item_i.elem) < MAP_DEPTH;
  assign row_ok  = 32'(item_i.row) < FREQ_DEPTH;
  assign is_map  = item_i.req_type == REQ_MAP;
  assign is_ext  = item_i.req_type == REQ_EXT;
  assign eidx    = item_i.elem[MAP_AW-1:0];

  // unobserved or out-of-range row clears the entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      ctl_q <= '0;
    end else begin
      if (acc_i && is_map && elem_ok) begin
        vld_q[eidx] <= item_i.observed && row_ok;
      end
      ctl_q.hit  <= acc_i && is_ext && elem_ok && vld_q[eidx];
      ctl_q.last <= acc_i && is_ext && item_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i && is_map && elem_ok && item_i.observed && row_ok) begin
      map_mem[eidx] <= item_i.row[ROW_AW-1:0];
    end
    if (acc_i) begin
      row_q <= map_mem[eidx];
    end
  end

  assign ctl_o = ctl_q;
  assign row_o = row_q;

endmodule

// ===== rtl/sdo_freq.sv =====
// Frequency table: one memory row per observed row, column write enables.
// Second pipeline stage, reads a whole row. Depends on sdo_pkg.
module sdo_freq #(
  parameter int N_OBS   = sdo_pkg::N_OBS_DEF,
  localparam int ROW_AW = sdo_pkg::row_aw(N_OBS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  sdo_pkg::in_item_t item_i,
  input  sdo_pkg::ctl_t     ctl_i,
  input  logic [ROW_AW-1:0] row_i,
  output sdo_pkg::ctl_t     ctl_o,
  output sdo_pkg::row_t     row_data_o
);
  import sdo_pkg::*;

  localparam int FREQ_DEPTH = obs_depth(N_OBS);

  row_t  freq_mem [FREQ_DEPTH];
  row_t  data_q;
  ctl_t  ctl_q;
  logic  wr_en;

  // col field spans exactly K columns
  assign wr_en = acc_i && (item_i.req_type == REQ_FREQ) &&
                 (32'(item_i.row) < FREQ_DEPTH);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      freq_mem[item_i.row[ROW_AW-1:0]][item_i.col] <= item_i.freq[FREQ_BITS-1:0];
    end
    data_q <= freq_mem[row_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  assign ctl_o      = ctl_q;
  assign row_data_o = data_q;

endmodule

// ===== rtl/sdo_accum.sv =====
// Running sums (saturating add) and pairwise dominance flags.
// Stages three and four; raises snap_o with the run's masks. Depends on sdo_pkg.
module sdo_accum (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sdo_pkg::ctl_t          ctl_i,
  input  sdo_pkg::row_t          row_data_i,
  input  logic [sdo_pkg::K-1:0]  col_en_i,
  output sdo_pkg::ctl_t          ctl_o,
  output logic                   snap_o,
  output sdo_pkg::mask_arr_t     masks_o
);
  import sdo_pkg::*;

  sum_t              sum_q  [K];
  sum_t              s3_q   [K];
  sum_t              sum_nx [K];
  logic [SUM_BITS:0] tot    [K];
  logic [K-1:0]      flags_q [K];
  logic [K-1:0]      flag_d  [K];
  ctl_t              ctl3_q;

  always_comb begin
    for (int a = 0; a < K; a++) begin
      tot[a]    = {1'b0, sum_q[a]} + (SUM_BITS + 1)'(row_data_i[a]);
      sum_nx[a] = sum_q[a];
      if (col_en_i[a]) begin
        sum_nx[a] = tot[a][SUM_BITS] ? '1 : tot[a][SUM_BITS-1:0];
      end
    end
  end

  // sums clear as the closing element leaves; stage four compares its copy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < K; a++) begin
        sum_q[a] <= '0;
      end
      ctl3_q <= '0;
    end else begin
      ctl3_q <= ctl_i;
      for (int a = 0; a < K; a++) begin
        if (ctl_i.last) begin
          sum_q[a] <= '0;
        end else if (ctl_i.hit) begin
          sum_q[a] <= sum_nx[a];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.hit) begin
      s3_q <= sum_nx;
    end
  end

  always_comb begin
    for (int a = 0; a < K; a++) begin
      for (int b = 0; b < K; b++) begin
        flag_d[a][b] = flags_q[a][b] &
                       !(ctl3_q.hit && col_en_i[a] && col_en_i[b] && (a != b) &&
                         (s3_q[a] < s3_q[b]));
        masks_o[a][b] = col_en_i[b] & ((a == b) | flag_d[a][b]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < K; a++) begin
        flags_q[a] <= '1;
      end
    end else begin
      for (int a = 0; a < K; a++) begin
        flags_q[a] <= ctl3_q.last ? '1 : flag_d[a];
      end
    end
  end

  assign snap_o = ctl3_q.last;
  assign ctl_o  = ctl3_q;

endmodule

// ===== rtl/sdo_out.sv =====
// Result buffer: holds one run's masks and sends one per transaction.
// Depends on sdo_pkg and sdo_if.
module sdo_out (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        snap_i,
  input  sdo_pkg::mask_arr_t          masks_i,
  input  logic [sdo_pkg::GROUP_W-1:0] col_last_i,
  sdo_out_if.source                   out_o
);
  import sdo_pkg::*;

  mask_arr_t          masks_q;
  logic               busy_q;
  logic [GROUP_W-1:0] idx_q;
  logic [GROUP_W-1:0] last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      last_q <= '0;
    end else if (snap_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      last_q <= col_last_i;
    end else if (busy_q && out_o.ready) begin
      if (idx_q == last_q) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_i) begin
      masks_q <= masks_i;
    end
  end

  assign out_o.valid               = busy_q;
  assign out_o.data.group_index    = idx_q;
  assign out_o.data.dominates_mask = masks_q[idx_q];
  assign out_o.data.last_res       = idx_q == last_q;

endmodule

// ===== rtl/stochastic_dominance_over_order_unit.sv =====
// Stochastic dominance of group columns along one linear extension.
// Throughput one input transaction per cycle; a closing element waits while
// an earlier closing element is in flight or its masks are still draining.
// A closing element passes the map, freq and accum registers; the buffer then sends
// one mask per column in use, one per cycle while out_o.ready holds. Reset: map all
// unobserved, sums zero, flags all ones, cols_in_use = 8; frequency table undefined.
module stochastic_dominance_over_order_unit #(
  parameter int POSET_SIZE = sdo_pkg::POSET_SIZE_DEF,
  parameter int N_OBS      = sdo_pkg::N_OBS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  sdo_in_if.sink                      in_i,
  sdo_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sdo_pkg::PADDR_W-1:0] paddr,
  input  logic [sdo_pkg::PDATA_W-1:0] pwdata,
  output logic [sdo_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import sdo_pkg::*;

  localparam int ROW_AW = row_aw(N_OBS);

  logic [COLS_W-1:0]  cfg_q;
  logic [K-1:0]       col_en_q;
  logic [GROUP_W-1:0] col_last_q;
  logic [COLS_W-1:0]  n_w;
  logic [K-1:0]       en_w;
  logic               cfg_wr, reg_hit;

  logic               acc;
  ctl_t               ctl1, ctl2, ctl3;
  logic [ROW_AW-1:0]  row1;
  row_t               row_data2;
  logic               snap;
  mask_arr_t          masks;
  logic               last_busy;

  // ---------------- configuration ----------------
  assign reg_hit = paddr[PADDR_W-1:2] == REG_COLS_IN_USE;
  assign cfg_wr  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? PDATA_W'(cfg_q) : '0;

  // zero acts as one, above K acts as K
  always_comb begin
    if (pwdata[COLS_W-1:0] == '0) begin
      n_w = COLS_W'(1);
    end else if (pwdata[COLS_W-1:0] > COLS_W'(K)) begin
      n_w = COLS_W'(K);
    end else begin
      n_w = pwdata[COLS_W-1:0];
    end
    for (int j = 0; j < K; j++) begin
      en_w[j] = COLS_W'(j) < n_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= COLS_W'(K);
      col_en_q   <= '1;
      col_last_q <= GROUP_W'(K - 1);
    end else if (cfg_wr) begin
      cfg_q      <= pwdata[COLS_W-1:0];
      col_en_q   <= en_w;
      col_last_q <= GROUP_W'(n_w - COLS_W'(1));
    end
  end

  // ---------------- input side ----------------
  assign last_busy = ctl1.last || ctl2.last || ctl3.last || out_o.valid;
  assign in_i.ready = !((in_i.data.req_type == REQ_EXT) && in_i.data.last && last_busy);
  assign acc        = in_i.valid && in_i.ready;

  sdo_map #(
    .POSET_SIZE (POSET_SIZE),
    .N_OBS      (N_OBS)
  ) u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .item_i (in_i.data),
    .ctl_o  (ctl1),
    .row_o  (row1)
  );

  sdo_freq #(
    .N_OBS (N_OBS)
  ) u_freq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .item_i     (in_i.data),
    .ctl_i      (ctl1),
    .row_i      (row1),
    .ctl_o      (ctl2),
    .row_data_o (row_data2)
  );

  sdo_accum u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl2),
    .row_data_i (row_data2),
    .col_en_i   (col_en_q),
    .ctl_o      (ctl3),
    .snap_o     (snap),
    .masks_o    (masks)
  );

  sdo_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .snap_i     (snap),
    .masks_i    (masks),
    .col_last_i (col_last_q),
    .out_o      (out_o)
  );

  // ---------------- assertions ----------------
  a_snap_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap |-> !out_o.valid)
    else $error("run closed while result buffer still draining");

  a_one_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({ctl1.last, ctl2.last, ctl3.last, out_o.valid}) <= 1)
    else $error("more than one closing element in flight");

  a_drain_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.data.last_res) |=> !out_o.valid)
    else $error("result buffer still valid after final mask transaction");

endmodule

// ===== bench/tb_stochastic_dominance_over_order_unit.sv =====
`timescale 1ns / 100ps
// Self-checking bench for stochastic_dominance_over_order_unit: directed and
// random load/extension traffic, an in-bench dominance predictor, APB setup.
// Depends on sdo_pkg, sdo_in_if / sdo_out_if and the unit itself.
module tb_stochastic_dominance_over_order_unit;
  import sdo_pkg::*;

  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam int         N_ELEMS      = POSET_SIZE_DEF;
  localparam int         N_ROWS       = N_OBS_DEF;
  localparam int         SETTLE_CYCLES = 12;
  localparam int         QUIET_LIMIT  = 2000;

  typedef struct {
    in_item_t item;
    bit       hold;   // wait until every pending mask has been taken
  } pending_t;

  logic clk_i;
  logic rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  sdo_in_if  in_bus ();
  sdo_out_if out_bus ();

  stochastic_dominance_over_order_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic                 obs_map_ok  [N_ELEMS];
  logic [5:0]           obs_map_row [N_ELEMS];
  logic [FREQ_BITS-1:0] freq_mem    [N_ROWS][K];
  logic [SUM_BITS-1:0]  col_sums    [K];
  logic [K-1:0]         dom_flags   [K];
  logic [COLS_W-1:0]    cols_cfg;

  // generator shadow, used to keep extension reads on fully loaded rows
  logic                 gen_map_ok   [N_ELEMS];
  logic [5:0]           gen_map_row  [N_ELEMS];
  logic [K-1:0]         gen_cols_set [N_ROWS];

  pending_t    items_pending [$];
  out_item_t   masks_due     [$];
  int unsigned mismatch_cnt;
  int unsigned tx_wait;
  int unsigned rx_wait;
  bit          no_idle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic int unsigned idle_draw();
    return no_idle ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic void clear_run();
    for (int g = 0; g < K; g++) begin
      col_sums[g]  = '0;
      dom_flags[g] = '1;
    end
  endfunction

  // One accepted transaction through the dominance predictor.
  function automatic void dominance_step(input in_item_t it);
    int unsigned         n;
    logic [SUM_BITS:0]   wide;
    logic [5:0]          r;
    logic [K-1:0]        used;
    out_item_t           res;
    n = (cols_cfg == 0) ? 1 : ((cols_cfg > K) ? K : cols_cfg);
    case (it.req_type)
      // row and col fields cannot leave the table at these widths
      REQ_FREQ: freq_mem[it.row][it.col] = it.freq;
      REQ_MAP: begin
        obs_map_ok[it.elem]  = it.observed;
        obs_map_row[it.elem] = it.row;
      end
      REQ_EXT: begin
        if (obs_map_ok[it.elem]) begin
          r = obs_map_row[it.elem];
          for (int a = 0; a < n; a++) begin
            wide = {1'b0, col_sums[a]} + freq_mem[r][a];
            col_sums[a] = wide[SUM_BITS] ? '1 : wide[SUM_BITS-1:0];
          end
          for (int a = 0; a < n; a++)
            for (int b = 0; b < n; b++)
              if (a != b && col_sums[a] < col_sums[b]) dom_flags[a][b] = 1'b0;
        end
        if (it.last) begin
          used = K'((1 << n) - 1);
          for (int a = 0; a < n; a++) begin
            res.group_index    = GROUP_W'(a);
            res.dominates_mask = (dom_flags[a] | K'(1 << a)) & used;
            res.last_res       = (a + 1 == n);
            masks_due = {masks_due, res};
          end
          clear_run();
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk_i or negedge rst_ni) begin : tx_side
    pending_t nxt;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) dominance_step(in_bus.data);
      if (!in_bus.valid || in_bus.ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_bus.valid <= 1'b0;
        end else if (items_pending.size() != 0 &&
                     !(items_pending[0].hold && masks_due.size() != 0)) begin
          nxt = items_pending.pop_front();
          in_bus.data  <= nxt.item;
          in_bus.valid <= 1'b1;
          tx_wait = idle_draw();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------- monitor
  always @(posedge clk_i or negedge rst_ni) begin : rx_side
    out_item_t want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (masks_due.size() == 0) begin
          note_mismatch($sformatf("mask with none pending: group %0d mask %02h last %0d",
                                  out_bus.data.group_index, out_bus.data.dominates_mask,
                                  out_bus.data.last_res));
        end else begin
          want = masks_due.pop_front();
          if (out_bus.data.group_index !== want.group_index ||
              out_bus.data.dominates_mask !== want.dominates_mask ||
              out_bus.data.last_res !== want.last_res)
            note_mismatch($sformatf(
              "group exp %0d got %0d, mask exp %02h got %02h, last exp %0d got %0d",
              want.group_index, out_bus.data.group_index,
              want.dominates_mask, out_bus.data.dominates_mask,
              want.last_res, out_bus.data.last_res));
        end
        rx_wait = idle_draw();
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_bus.ready <= (rx_wait == 0);
    end
  end

  // Ends the run when no transaction moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_stochastic_dominance_over_order_unit: done, errors");
    $finish;
  end

  // -------------------------------------------------------------- stimulus
  task automatic push_item(input logic [1:0] req, input logic [7:0] elem,
                           input logic [5:0] row, input logic [2:0] col,
                           input logic [15:0] freq, input logic obs,
                           input logic close, input bit hold);
    pending_t p;
    p.item = '{req_type: req, elem: elem, row: row, col: col, freq: freq,
               observed: obs, last: close};
    p.hold = hold;
    items_pending = {items_pending, p};
    if (req == REQ_FREQ) begin
      gen_cols_set[row][col] = 1'b1;
    end else if (req == REQ_MAP) begin
      gen_map_ok[elem]  = obs;
      gen_map_row[elem] = row;
    end
  endtask

  function automatic logic [15:0] pick_freq();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bit elem_safe(input logic [7:0] e);
    return !gen_map_ok[e] || (&gen_cols_set[gen_map_row[e]]);
  endfunction

  // Random element whose row, if any, is fully loaded.
  function automatic logic [7:0] pick_elem(input bit want_hit);
    logic [7:0] cand [$];
    for (int e = 0; e < N_ELEMS; e++)
      if (elem_safe(8'(e)) && gen_map_ok[e] == want_hit) cand = {cand, 8'(e)};
    if (cand.size() == 0)
      for (int e = 0; e < N_ELEMS; e++)
        if (elem_safe(8'(e))) cand = {cand, 8'(e)};
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  task automatic freq_load(input logic [5:0] row, input logic [2:0] col,
                           input logic [15:0] freq);
    push_item(REQ_FREQ, 8'($urandom), row, col, freq, 1'($urandom), 1'($urandom), 1'b0);
  endtask

  task automatic map_load(input logic [7:0] elem, input logic [5:0] row, input logic obs);
    push_item(REQ_MAP, elem, row, 3'($urandom), 16'($urandom), obs, 1'($urandom), 1'b0);
  endtask

  task automatic ext_item(input logic [7:0] elem, input logic close, input bit hold);
    push_item(REQ_EXT, elem, 6'($urandom), 3'($urandom), 16'($urandom), 1'($urandom),
              close, hold);
  endtask

  // all eight columns of a row, in a scrambled order
  task automatic fill_row(input logic [5:0] row);
    int unsigned start;
    int unsigned stride;
    start  = $urandom_range(0, K - 1);
    stride = 2 * $urandom_range(0, 3) + 1;
    for (int i = 0; i < K; i++) freq_load(row, 3'((start + i * stride) % K), pick_freq());
  endtask

  task automatic ext_run(input int unsigned len, input bit close);
    for (int i = 0; i < len; i++)
      ext_item(pick_elem($urandom_range(0, 4) != 0), close && (i == len - 1),
               (i == 0) && ($urandom_range(0, 7) == 0));
  endtask

  task automatic drain_wait();
    while (items_pending.size() != 0 || in_bus.valid || masks_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [COLS_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_COLS_IN_USE, 2'b00};
    pwdata  <= PDATA_W'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    cols_cfg = val;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // read it back
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata[COLS_W-1:0] !== val)
      note_mismatch($sformatf("cols_in_use read exp %0d got %0d", val, prdata[COLS_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : stimulus
    logic [15:0]       dir_hi [K];
    logic [15:0]       dir_lo [K];
    logic [COLS_W-1:0] phase_cols [8];
    logic [5:0]        full_rows [$];
    logic [5:0]        r;
    int unsigned       made;
    int unsigned       len;

    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    out_bus.ready = 1'b0;
    mismatch_cnt  = 0;
    no_idle       = 1'b0;
    cols_cfg      = COLS_W'(K);
    for (int e = 0; e < N_ELEMS; e++) begin
      obs_map_ok[e]  = 1'b0;
      obs_map_row[e] = '0;
      gen_map_ok[e]  = 1'b0;
      gen_map_row[e] = '0;
    end
    for (int i = 0; i < N_ROWS; i++) begin
      gen_cols_set[i] = '0;
      for (int j = 0; j < K; j++) freq_mem[i][j] = '0;
    end
    clear_run();

    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extreme rows, hit / miss / repeat, empty run, ignored codes
    dir_hi = '{16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h0000,
               16'hFFFE};
    dir_lo = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'hFFFF, 16'h0000, 16'h7FFF,
               16'h1234};
    for (int j = 0; j < K; j++) begin
      freq_load(6'd63, 3'(j), dir_hi[j]);
      freq_load(6'd0, 3'(j), dir_lo[j]);
    end
    map_load(8'd255, 6'd63, 1'b1);
    map_load(8'd0, 6'd0, 1'b1);
    map_load(8'd7, 6'd0, 1'b0);
    ext_item(8'd0, 1'b0, 1'b0);
    ext_item(8'd7, 1'b0, 1'b0);      // unobserved: no add
    ext_item(8'd255, 1'b0, 1'b0);
    ext_item(8'd255, 1'b1, 1'b0);    // repeated element closes the run
    push_item(REQ_UNUSED, 8'hFF, 6'h3F, 3'h7, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    push_item(REQ_MAP, 8'd7, 6'd63, 3'd0, 16'h0000, 1'b0, 1'b1, 1'b0);
    ext_item(8'd7, 1'b1, 1'b0);      // run with no observed element
    drain_wait();

    // saturation: column 0 pins at full scale, column 1 climbs to meet it
    reg_write(COLS_W'(2));
    for (int j = 0; j < K; j++) begin
      freq_load(6'd1, 3'(j), (j == 0) ? 16'hFFFF : ((j == 1) ? 16'hF000 : pick_freq()));
      freq_load(6'd2, 3'(j), (j == 0) ? 16'h0000 : ((j == 1) ? 16'hFFFF : pick_freq()));
    end
    map_load(8'd10, 6'd1, 1'b1);
    map_load(8'd11, 6'd2, 1'b1);
    repeat (65) ext_item(8'd10, 1'b0, 1'b0);
    for (int i = 0; i < 5; i++) ext_item(8'd11, 1'b0, 1'b0);
    ext_item(8'd7, 1'b1, 1'b0);
    drain_wait();

    // random phases, one column setting each
    phase_cols = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd9, 4'd5, 4'd7};
    for (int p = 0; p < 8; p++) begin
      reg_write((p >= 6) ? COLS_W'($urandom_range(0, 15)) : phase_cols[p]);
      no_idle = (p % 3 == 1);
      made = 0;
      while (made < 4) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            fill_row(6'($urandom));
            made += K;
          end
          2, 3: begin
            full_rows.delete();
            for (int i = 0; i < N_ROWS; i++)
              if (&gen_cols_set[i]) full_rows = {full_rows, 6'(i)};
            if (full_rows.size() != 0 && $urandom_range(0, 1) == 0)
              r = full_rows[$urandom_range(0, full_rows.size() - 1)];
            else
              r = 6'($urandom);
            map_load(8'($urandom), r, $urandom_range(0, 3) != 0);
            made++;
          end
          4, 5, 6, 7: begin
            len = $urandom_range(1, 6);
            ext_run(len, 1'b1);
            made += len;
          end
          8: begin
            if ($urandom_range(0, 1) == 0)
              push_item(REQ_UNUSED, 8'($urandom), 6'($urandom), 3'($urandom),
                        16'($urandom), 1'($urandom), 1'($urandom), 1'b0);
            else
              ext_item(pick_elem(1'b0), 1'b0, 1'b0);
            made++;
          end
          default: begin
            // open run, left to run into whatever follows
            len = $urandom_range(1, 3);
            ext_run(len, 1'b0);
            made += len;
          end
        endcase
      end
      ext_item(pick_elem(1'b1), 1'b1, 1'b0);
      drain_wait();
    end

    if (mismatch_cnt == 0) begin
      $display("tb_stochastic_dominance_over_order_unit: done, clean");
    end else begin
      $display("tb_stochastic_dominance_over_order_unit: done, errors");
    end
    $finish;
  end

endmodule
